FILE: hdl/matrix3x3_inverse_macros.svh
// Assertion macros for the matrix3x3_inverse block.
`ifndef MATRIX3X3_INVERSE_MACROS_SVH
`define MATRIX3X3_INVERSE_MACROS_SVH
`ifndef SYNTH
`define MI3_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("mi3 assertion failed");
`define MI3_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("mi3 assertion failed");
`else
`define MI3_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MI3_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif
`endif

FILE: hdl/mi3_pkg.sv
// Shared types and constants of the 3x3 matrix inverse pipeline.
`timescale 1ns / 1ps
package mi3_pkg;
	localparam int ELEM_W = 16;
	localparam int FRAC_BITS = 8;
	localparam int PROD_W = 2 * ELEM_W;
	localparam int COF_W = 2 * ELEM_W + 1;
	localparam int DET_W = 3 * ELEM_W + 1;
	localparam int DMAG_W = 3 * ELEM_W;
	localparam int CMAG_W = 2 * ELEM_W;
	localparam int SHIFT = 2 * FRAC_BITS;
	localparam int REM_W = CMAG_W + SHIFT;
	localparam int QUO_W = ELEM_W;
	localparam int TRIAL_W = DMAG_W + QUO_W;
	localparam int NUM_EL = 9;
	// stage where the divider lanes start and the last stage before the output register
	localparam int DIV_START = 6;
	localparam int LAST_STAGE = DIV_START + QUO_W;

	typedef logic signed [ELEM_W-1:0] elem_t;
	typedef logic signed [PROD_W-1:0] prod_t;
	typedef logic signed [COF_W-1:0] cof_t;
	typedef logic signed [DET_W-1:0] det_t;
	typedef logic [DMAG_W-1:0] dmag_t;

	typedef struct packed {
		dmag_t dmag;
		logic  dneg;
		logic  zero;
	} det_info_t;
endpackage

FILE: hdl/matrix3x3_inverse.sv
// Top level of the 3x3 fixed-point matrix inverse pipeline.
// Takes one Q8.8 3x3 matrix per cycle while mat_ready is high and returns its
// inverse (Q8.8, truncated toward zero, saturated), the exact Q24.24
// determinant and a singular flag. Between acceptance and inv_valid lie two
// stages of cofactors, three of determinant, nine parallel restoring divider
// lanes (operand register, then one quotient bit per stage, combinational
// range step) and the output register. The whole pipeline advances together;
// mat_ready drops only while a finished result sits unaccepted at the output.
`timescale 1ns / 1ps
`include "matrix3x3_inverse_macros.svh"
module matrix3x3_inverse (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 mat_valid,
	output logic                 mat_ready,
	input  mi3_pkg::elem_t       m00, m01, m02,
	input  mi3_pkg::elem_t       m10, m11, m12,
	input  mi3_pkg::elem_t       m20, m21, m22,
	output logic                 inv_valid,
	input  logic                 inv_ready,
	output mi3_pkg::elem_t       inv00, inv01, inv02,
	output mi3_pkg::elem_t       inv10, inv11, inv12,
	output mi3_pkg::elem_t       inv20, inv21, inv22,
	output mi3_pkg::det_t        determinant,
	output logic                 singular
);
	import mi3_pkg::*;

	logic      en;
	elem_t     a[NUM_EL];
	cof_t      cof[NUM_EL];
	elem_t     row0[3];
	det_t      det_s4;
	det_info_t info_s5;
	elem_t     quo[NUM_EL];

	logic [LAST_STAGE:1] vld_q;
	det_t  det_s [LAST_STAGE+1];
	logic  zero_s[LAST_STAGE+1];
	elem_t inv_q[NUM_EL];
	det_t  det_q;
	logic  sing_q;

	assign en = !inv_valid || inv_ready;
	assign mat_ready = en;

	assign a[0] = m00; assign a[1] = m01; assign a[2] = m02;
	assign a[3] = m10; assign a[4] = m11; assign a[5] = m12;
	assign a[6] = m20; assign a[7] = m21; assign a[8] = m22;

	mi3_cofactor u_cof (.clk(clk), .en(en), .a(a), .cof(cof), .row0(row0));
	mi3_det u_det (.clk(clk), .en(en), .cof(cof), .row0(row0), .det(det_s4), .info(info_s5));

	for (genvar k = 0; k < NUM_EL; k++) begin : g_lane
		mi3_div u_div (.clk(clk), .en(en), .cof(cof[k]), .info(info_s5), .quo(quo[k]));
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			inv_valid <= 1'b0;
		end else if (en) begin
			vld_q <= {vld_q[LAST_STAGE-1:1], mat_valid};
			inv_valid <= vld_q[LAST_STAGE];
		end
	end

	assign det_s[4] = det_s4;
	assign zero_s[5] = info_s5.zero;
	assign zero_s[4] = 1'b0;
	for (genvar s = 0; s < 4; s++) begin : g_unused
		assign det_s[s] = '0;
		assign zero_s[s] = 1'b0;
	end

	for (genvar s = 5; s <= LAST_STAGE; s++) begin : g_dly
		always_ff @(posedge clk) begin
			if (en) begin
				det_s[s] <= det_s[s-1];
			end
		end
		if (s > 5) begin : g_z
			always_ff @(posedge clk) begin
				if (en) begin
					zero_s[s] <= zero_s[s-1];
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int k = 0; k < NUM_EL; k++) begin
				inv_q[k] <= zero_s[LAST_STAGE] ? '0 : quo[k];
			end
			det_q <= det_s[LAST_STAGE];
			sing_q <= zero_s[LAST_STAGE];
		end
	end

	assign inv00 = inv_q[0]; assign inv01 = inv_q[1]; assign inv02 = inv_q[2];
	assign inv10 = inv_q[3]; assign inv11 = inv_q[4]; assign inv12 = inv_q[5];
	assign inv20 = inv_q[6]; assign inv21 = inv_q[7]; assign inv22 = inv_q[8];
	assign determinant = det_q;
	assign singular = sing_q;

	`MI3_ASSERT_IMP(a_sing_det, clk, arst_n, inv_valid, (singular == (determinant == '0)))
	`MI3_ASSERT_IMP(a_sing_zero, clk, arst_n, inv_valid && singular, (inv00 == '0) && (inv22 == '0))
	`MI3_ASSERT_NXT(a_stall_hold, clk, arst_n, !en, $stable(vld_q))
endmodule

FILE: hdl/mi3_cofactor.sv
// Stages 1-2: products of element pairs and the nine cofactors.
`timescale 1ns / 1ps
module mi3_cofactor (
	input  logic                clk,
	input  logic                en,
	input  mi3_pkg::elem_t      a   [mi3_pkg::NUM_EL],
	output mi3_pkg::cof_t       cof [mi3_pkg::NUM_EL],
	output mi3_pkg::elem_t      row0[3]
);
	import mi3_pkg::*;

	prod_t pa_s1 [NUM_EL];
	prod_t pb_s1 [NUM_EL];
	elem_t row0_s1[3];
	cof_t  cof_s2 [NUM_EL];
	elem_t row0_s2[3];

	always_ff @(posedge clk) begin
		if (en) begin
			pa_s1[0] <= a[4] * a[8]; pb_s1[0] <= a[5] * a[7];
			pa_s1[1] <= a[2] * a[7]; pb_s1[1] <= a[1] * a[8];
			pa_s1[2] <= a[1] * a[5]; pb_s1[2] <= a[2] * a[4];
			pa_s1[3] <= a[5] * a[6]; pb_s1[3] <= a[3] * a[8];
			pa_s1[4] <= a[0] * a[8]; pb_s1[4] <= a[2] * a[6];
			pa_s1[5] <= a[2] * a[3]; pb_s1[5] <= a[0] * a[5];
			pa_s1[6] <= a[3] * a[7]; pb_s1[6] <= a[4] * a[6];
			pa_s1[7] <= a[1] * a[6]; pb_s1[7] <= a[0] * a[7];
			pa_s1[8] <= a[0] * a[4]; pb_s1[8] <= a[1] * a[3];
			for (int i = 0; i < 3; i++) begin
				row0_s1[i] <= a[i];
				row0_s2[i] <= row0_s1[i];
			end
			for (int k = 0; k < NUM_EL; k++) begin
				cof_s2[k] <= cof_t'(pa_s1[k]) - cof_t'(pb_s1[k]);
			end
		end
	end

	assign cof = cof_s2;
	assign row0 = row0_s2;
endmodule

FILE: hdl/mi3_det.sv
// Stages 3-5: determinant by first-row expansion, then sign and magnitude.
`timescale 1ns / 1ps
module mi3_det (
	input  logic                clk,
	input  logic                en,
	input  mi3_pkg::cof_t       cof [mi3_pkg::NUM_EL],
	input  mi3_pkg::elem_t      row0[3],
	output mi3_pkg::det_t       det,
	output mi3_pkg::det_info_t  info
);
	import mi3_pkg::*;

	det_t      t_s3[3];
	det_t      det_s4;
	det_info_t info_s5;

	always_ff @(posedge clk) begin
		if (en) begin
			t_s3[0] <= det_t'(row0[0]) * det_t'(cof[0]);
			t_s3[1] <= det_t'(row0[1]) * det_t'(cof[3]);
			t_s3[2] <= det_t'(row0[2]) * det_t'(cof[6]);
			// exact value always fits DET_W, so modular sum is exact
			det_s4 <= t_s3[0] + t_s3[1] + t_s3[2];
			info_s5.dneg <= det_s4[DET_W-1];
			info_s5.zero <= (det_s4 == '0);
			info_s5.dmag <= det_s4[DET_W-1] ? dmag_t'(-det_s4) : dmag_t'(det_s4);
		end
	end

	assign det = det_s4;
	assign info = info_s5;
endmodule

FILE: hdl/mi3_div.sv
// One divider lane: cofactor / determinant, restoring, one quotient bit per stage.
`timescale 1ns / 1ps
module mi3_div (
	input  logic                clk,
	input  logic                en,
	input  mi3_pkg::cof_t       cof,
	input  mi3_pkg::det_info_t  info,
	output mi3_pkg::elem_t      quo
);
	import mi3_pkg::*;

	cof_t              cof_s3, cof_s4;
	logic [CMAG_W-1:0] cmag_s5;
	logic              cneg_s5;

	// index 0 is stage DIV_START, index k is DIV_START + k
	logic [REM_W-1:0]  rem_s [QUO_W+1];
	dmag_t             den_s [QUO_W+1];
	logic [QUO_W-1:0]  q_s   [QUO_W+1];
	logic              ovf_s [QUO_W+1];
	logic              qneg_s[QUO_W+1];

	always_ff @(posedge clk) begin
		if (en) begin
			cof_s3 <= cof;
			cof_s4 <= cof_s3;
			cneg_s5 <= cof_s4[COF_W-1];
			cmag_s5 <= cof_s4[COF_W-1] ? CMAG_W'(-cof_s4) : CMAG_W'(cof_s4);
			// quotient >= 2^QUO_W exactly when |cof| >= |det|
			ovf_s[0] <= (DMAG_W'(cmag_s5) >= info.dmag);
			rem_s[0] <= {cmag_s5, {SHIFT{1'b0}}};
			den_s[0] <= info.dmag;
			q_s[0] <= '0;
			qneg_s[0] <= cneg_s5 ^ info.dneg;
		end
	end

	for (genvar k = 0; k < QUO_W; k++) begin : g_bit
		localparam int B = QUO_W - 1 - k;
		logic [TRIAL_W-1:0] trial;
		logic               fits;
		assign trial = {{QUO_W{1'b0}}, den_s[k]} << B;
		assign fits = (TRIAL_W'(rem_s[k]) >= trial);
		always_ff @(posedge clk) begin
			if (en) begin
				rem_s[k+1] <= fits ? (rem_s[k] - trial[REM_W-1:0]) : rem_s[k];
				q_s[k+1] <= q_s[k] | (fits ? (QUO_W'(1) << B) : '0);
				den_s[k+1] <= den_s[k];
				ovf_s[k+1] <= ovf_s[k];
				qneg_s[k+1] <= qneg_s[k];
			end
		end
	end

	logic [QUO_W-1:0] limit, mag;
	always_comb begin
		limit = qneg_s[QUO_W] ? {1'b1, {(QUO_W-1){1'b0}}} : {1'b0, {(QUO_W-1){1'b1}}};
		mag = (ovf_s[QUO_W] || (q_s[QUO_W] > limit)) ? limit : q_s[QUO_W];
		quo = qneg_s[QUO_W] ? elem_t'(-mag) : elem_t'(mag);
	end
endmodule

FILE: tb/sv/matrix3x3_inverse_tb.sv
// Self-checking testbench for the 3x3 fixed-point matrix inverse pipeline.
`timescale 1ns / 1ps
module matrix3x3_inverse_tb;
	import mi3_pkg::*;

	typedef struct {
		elem_t inv[9];
		det_t  det;
		logic  sing;
	} inv_res_t;

	typedef struct {
		elem_t    mat[9];
		bit       typed;
		inv_res_t res;
	} mat_row_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic mat_valid = 1'b0;
	logic inv_ready = 1'b0;
	logic mat_ready, inv_valid, singular;
	elem_t mat_drv[9];
	elem_t inv_out[9];
	det_t determinant;

	inv_res_t inv_expected[$];
	mat_row_t dir_rows[$];
	int errors = 0;
	int mats_sent = 0;
	int invs_checked = 0;
	int singular_seen = 0;
	int send_idle_pct = 0;
	int recv_idle_pct = 0;
	bit recv_hold_req = 1'b0;

	initial for (int k = 0; k < 9; k++) mat_drv[k] = '0;

	always #1 clk = ~clk;

	matrix3x3_inverse DUT (
		.clk(clk), .arst_n(arst_n),
		.mat_valid(mat_valid), .mat_ready(mat_ready),
		.m00(mat_drv[0]), .m01(mat_drv[1]), .m02(mat_drv[2]),
		.m10(mat_drv[3]), .m11(mat_drv[4]), .m12(mat_drv[5]),
		.m20(mat_drv[6]), .m21(mat_drv[7]), .m22(mat_drv[8]),
		.inv_valid(inv_valid), .inv_ready(inv_ready),
		.inv00(inv_out[0]), .inv01(inv_out[1]), .inv02(inv_out[2]),
		.inv10(inv_out[3]), .inv11(inv_out[4]), .inv12(inv_out[5]),
		.inv20(inv_out[6]), .inv21(inv_out[7]), .inv22(inv_out[8]),
		.determinant(determinant), .singular(singular)
	);

	function automatic inv_res_t predict_inverse(elem_t a[9]);
		longint e[9], c[9];
		longint d, dm, q;
		bit dneg, qneg;
		inv_res_t r;
		for (int k = 0; k < 9; k++) e[k] = a[k];
		c[0] = e[4] * e[8] - e[5] * e[7];
		c[1] = e[2] * e[7] - e[1] * e[8];
		c[2] = e[1] * e[5] - e[2] * e[4];
		c[3] = e[5] * e[6] - e[3] * e[8];
		c[4] = e[0] * e[8] - e[2] * e[6];
		c[5] = e[2] * e[3] - e[0] * e[5];
		c[6] = e[3] * e[7] - e[4] * e[6];
		c[7] = e[1] * e[6] - e[0] * e[7];
		c[8] = e[0] * e[4] - e[1] * e[3];
		d = e[0] * c[0] + e[1] * c[3] + e[2] * c[6];
		r.det = d[DET_W-1:0];
		r.sing = (d == 0);
		dneg = d < 0;
		dm = dneg ? -d : d;
		for (int k = 0; k < 9; k++) begin
			if (d == 0) begin
				r.inv[k] = '0;
			end else begin
				qneg = (c[k] < 0) != dneg;
				q = ((c[k] < 0 ? -c[k] : c[k]) <<< SHIFT) / dm;
				if (qneg)
					r.inv[k] = (q > 32768) ? elem_t'(-32768) : elem_t'(-q);
				else
					r.inv[k] = (q > 32767) ? elem_t'(32767) : elem_t'(q);
			end
		end
		return r;
	endfunction

	task automatic report_mismatch(string field, longint got, longint want);
		$display("mismatch on item %0d: %s got %0d expected %0d", invs_checked, field, got, want);
		errors++;
	endtask

	// result monitor
	always @(posedge clk) begin
		inv_res_t w;
		if (arst_n && inv_valid && inv_ready) begin
			if (inv_expected.size() == 0) begin
				report_mismatch("result count", invs_checked + 1, mats_sent);
			end else begin
				w = inv_expected.pop_front();
				for (int k = 0; k < 9; k++)
					if (inv_out[k] !== w.inv[k])
						report_mismatch($sformatf("inv%0d%0d", k / 3, k % 3), inv_out[k], w.inv[k]);
				if (determinant !== w.det) report_mismatch("determinant", determinant, w.det);
				if (singular !== w.sing) report_mismatch("singular", singular, w.sing);
				if (w.sing) singular_seen++;
			end
			invs_checked++;
		end
	end

	// receiver; a hold request keeps ready low for a long counted stretch
	initial begin
		int hold_left;
		hold_left = 0;
		forever begin
			@(negedge clk);
			if (recv_hold_req && hold_left == 0) begin
				hold_left = 300;
				recv_hold_req = 1'b0;
			end
			if (hold_left > 0) begin
				hold_left--;
				inv_ready = 1'b0;
			end else begin
				inv_ready = ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	task automatic send_matrix(elem_t a[9], bit typed, inv_res_t res);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			mat_valid = 1'b0;
			@(negedge clk);
		end
		for (int k = 0; k < 9; k++) mat_drv[k] = a[k];
		mat_valid = 1'b1;
		do @(posedge clk); while (!mat_ready);
		inv_expected.push_back(typed ? res : predict_inverse(a));
		mats_sent++;
	endtask

	task automatic add_row(elem_t a[9], bit typed, inv_res_t res);
		mat_row_t row;
		row.mat = a;
		row.typed = typed;
		row.res = res;
		dir_rows.push_back(row);
	endtask

	function automatic inv_res_t diag_res(elem_t v, det_t d, logic s);
		inv_res_t r;
		for (int k = 0; k < 9; k++) r.inv[k] = (k % 4 == 0) ? v : elem_t'(0);
		r.det = d;
		r.sing = s;
		return r;
	endfunction

	function automatic void scaled_eye(output elem_t a[9], input elem_t v);
		for (int k = 0; k < 9; k++) a[k] = (k % 4 == 0) ? v : elem_t'(0);
	endfunction

	function automatic void random_matrix(output elem_t a[9]);
		int kind;
		int s;
		kind = $urandom_range(99);
		for (int k = 0; k < 9; k++) a[k] = elem_t'($urandom);
		if (kind < 50) begin
			// diagonal magnitudes 64 to 2048, off-diagonal elements -256 to 256
			for (int k = 0; k < 9; k++)
				a[k] = (k % 4 == 0) ? elem_t'($urandom_range(2048, 64) * ($urandom_range(1) ? 1 : -1))
					: elem_t'($signed($urandom_range(512)) - 256);
		end else if (kind < 65) begin
			// third row set to the first times a small factor: singular unless the product wraps
			s = $signed($urandom_range(8)) - 4;
			for (int k = 0; k < 3; k++) a[6 + k] = elem_t'(a[k] * s);
			if (s == 0 && $urandom_range(1)) for (int k = 0; k < 9; k++) a[k] = a[k] >>> 12;
		end else if (kind < 80) begin
			// tiny elements, so large quotients that can saturate
			for (int k = 0; k < 9; k++) a[k] = elem_t'($signed($urandom_range(6)) - 3);
		end
	endfunction

	initial begin
		elem_t a[9];
		inv_res_t none;
		none = diag_res(0, 0, 0);

		scaled_eye(a, 0);      add_row(a, 1, diag_res(0, 0, 1));
		scaled_eye(a, 256);    add_row(a, 1, diag_res(256, det_t'(1) << 24, 0));
		scaled_eye(a, 512);    add_row(a, 1, diag_res(128, det_t'(1) << 27, 0));
		scaled_eye(a, 1);      add_row(a, 1, diag_res(32767, 1, 0));
		scaled_eye(a, -1);     add_row(a, 1, diag_res(-32768, -1, 0));
		scaled_eye(a, -256);   add_row(a, 1, diag_res(-256, -(det_t'(1) << 24), 0));
		for (int k = 0; k < 9; k++) a[k] = -32768;
		add_row(a, 1, diag_res(0, 0, 1));
		for (int k = 0; k < 9; k++) a[k] = 32767;
		add_row(a, 1, diag_res(0, 0, 1));
		scaled_eye(a, 32767);  add_row(a, 0, none);
		scaled_eye(a, -32768); add_row(a, 0, none);
		for (int k = 0; k < 9; k++) a[k] = (k == 0 || k == 4 || k == 8) ? -32768 : 32767;
		add_row(a, 0, none);
		for (int k = 0; k < 9; k++) a[k] = (k % 2) ? 32767 : -32768;
		add_row(a, 0, none);
		a = '{256, 512, 768, 0, 256, 1024, 1280, 1536, 0};     add_row(a, 0, none);
		a = '{0, 256, 0, 256, 0, 0, 0, 0, 256};                add_row(a, 0, none);
		a = '{384, -128, 64, 32, 640, -256, -96, 48, 1024};    add_row(a, 0, none);
		a = '{3, 1, 0, 1, 2, 1, 0, 1, 3};                      add_row(a, 0, none);
		a = '{32767, 32767, 0, 0, 32767, 32767, 32767, 0, 32767};
		add_row(a, 0, none);

		send_idle_pct = 27;
		recv_idle_pct = 50;
		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		foreach (dir_rows[i]) send_matrix(dir_rows[i].mat, dir_rows[i].typed, dir_rows[i].res);

		for (int phase = 0; phase < 3; phase++) begin
			send_idle_pct = (phase == 0) ? 27 : (phase == 1) ? 50 : 0;
			recv_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 27 : 0;
			if (phase == 1) recv_hold_req = 1'b1;
			for (int n = 0; n < 530; n++) begin
				random_matrix(a);
				send_matrix(a, 0, none);
			end
			// pause until the pipeline has drained
			@(negedge clk);
			mat_valid = 1'b0;
			wait (inv_expected.size() == 0);
		end

		repeat (40) @(posedge clk);
		$display("sent %0d matrices, checked %0d inverses (%0d singular)",
			mats_sent, invs_checked, singular_seen);
		$display("covered extremes, saturation, singular inputs and three stall mixes");
		if (errors == 0 && inv_expected.size() == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end

	initial begin
		#2000000;
		$display("timeout with %0d results outstanding", inv_expected.size());
		$display("FAILED: results differ");
		$finish;
	end
endmodule
